// ===== design/glcd_pkg.sv =====
// Shared types, constants and helper functions for the graphic LCD frame refresher.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package glcd_pkg;

	localparam int ROW_BYTES     = 16;
	localparam int ROWS_PER_HALF = 32;

	localparam int COL_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int Y_W   = (ROWS_PER_HALF > 1) ? $clog2(ROWS_PER_HALF) : 1;

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(ROW_BYTES - 1);
	localparam logic [Y_W-1:0]   Y_LAST   = Y_W'(ROWS_PER_HALF - 1);

	localparam logic [7:0] CMD_SYNC    = 8'hF8;
	localparam logic [7:0] DAT_SYNC    = 8'hFA;
	localparam logic [7:0] ADDR_BASE   = 8'h80;
	localparam logic [7:0] HALF_OFFSET = 8'h08;
	localparam logic [7:0] HI_MASK     = 8'hF0;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified framebuffer byte waiting for serialization.
	typedef struct packed {
		logic [7:0]     pixel;
		logic           row_start;
		logic           release_sel;
		logic [Y_W-1:0] y;
		logic           half;
	} glcd_item_t;

	function automatic logic [7:0] hi_nibble(input logic [7:0] b);
		return b & HI_MASK;
	endfunction

	function automatic logic [7:0] lo_nibble(input logic [7:0] b);
		return {b[3:0], 4'b0000};
	endfunction

endpackage

// ===== design/glcd_front.sv =====
// Front end: accepts framebuffer bytes, tracks the column, row and half position,
// and classifies each byte for the back end. Depends on glcd_pkg.
module glcd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          pixel_byte,
	input  logic                frame_start,
	input  logic                q_full,
	output logic                q_push,
	output glcd_pkg::glcd_item_t q_item
);
	import glcd_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [Y_W-1:0]   y_q;
	logic             half_q;

	logic [COL_W-1:0] col_cur;
	logic [Y_W-1:0]   y_cur;
	logic             half_cur;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// A frame restart applies to the byte that carries it.
	assign col_cur  = frame_start ? '0 : col_q;
	assign y_cur    = frame_start ? '0 : y_q;
	assign half_cur = frame_start ? 1'b0 : half_q;

	always_comb begin
		q_item.pixel       = pixel_byte;
		q_item.row_start   = (col_cur == '0);
		q_item.release_sel = (col_cur == COL_LAST) && (y_cur == Y_LAST);
		q_item.y           = y_cur;
		q_item.half        = half_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			y_q    <= '0;
			half_q <= 1'b0;
		end else if (q_push) begin
			if (col_cur == COL_LAST) begin
				col_q <= '0;
				if (y_cur == Y_LAST) begin
					y_q    <= '0;
					half_q <= !half_cur;
				end else begin
					y_q    <= y_cur + 1'b1;
					half_q <= half_cur;
				end
			end else begin
				col_q  <= col_cur + 1'b1;
				y_q    <= y_cur;
				half_q <= half_cur;
			end
		end
	end

endmodule

// ===== design/glcd_queue.sv =====
// Short register queue that decouples the classifying front from the serializing back.
// Depends on glcd_pkg for the item type and depth.
module glcd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  glcd_pkg::glcd_item_t push_item,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output glcd_pkg::glcd_item_t head_item
);
	import glcd_pkg::*;

	glcd_item_t        entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/glcd_back.sv =====
// Back end: walks each queued item through its serial byte sequence into an
// output register, one serial byte per cycle while the receiver is ready. Depends on glcd_pkg.
module glcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  glcd_pkg::glcd_item_t head_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          spi_byte,
	output logic                release_select,
	output logic                last_of_run
);
	import glcd_pkg::*;

	typedef enum logic [2:0] {
		ST_CMD_SYNC = 3'd0,
		ST_ROW_HI   = 3'd1,
		ST_ROW_LO   = 3'd2,
		ST_COL_HI   = 3'd3,
		ST_COL_LO   = 3'd4,
		ST_DAT_SYNC = 3'd5,
		ST_PIX_HI   = 3'd6,
		ST_PIX_LO   = 3'd7
	} step_t;

	logic [2:0] step_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       rel_q;
	logic       last_q;

	step_t      step;
	logic       load;
	logic [7:0] row_addr;
	logic [7:0] col_addr;
	logic [7:0] next_byte;

	// Bytes that do not start a row skip the header and begin at the pixel nibbles.
	assign step     = step_t'(head_item.row_start ? step_q : step_q + 3'd6);
	assign load     = head_valid && (!valid_q || out_ready);
	assign pop      = load && (step == ST_PIX_LO);
	assign row_addr = ADDR_BASE | 8'(head_item.y);
	assign col_addr = head_item.half ? (ADDR_BASE | HALF_OFFSET) : ADDR_BASE;

	always_comb begin
		case (step)
			ST_CMD_SYNC: next_byte = CMD_SYNC;
			ST_ROW_HI:   next_byte = hi_nibble(row_addr);
			ST_ROW_LO:   next_byte = lo_nibble(row_addr);
			ST_COL_HI:   next_byte = hi_nibble(col_addr);
			ST_COL_LO:   next_byte = lo_nibble(col_addr);
			ST_DAT_SYNC: next_byte = DAT_SYNC;
			ST_PIX_HI:   next_byte = hi_nibble(head_item.pixel);
			ST_PIX_LO:   next_byte = lo_nibble(head_item.pixel);
			default:     next_byte = CMD_SYNC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
			byte_q  <= '0;
			rel_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q  <= pop ? 3'd0 : step_q + 3'd1;
				byte_q  <= next_byte;
				rel_q   <= pop && head_item.release_sel;
				last_q  <= pop;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = valid_q;
	assign spi_byte       = byte_q;
	assign release_select = rel_q;
	assign last_of_run    = last_q;

endmodule

// ===== design/glcd_serial_frame_refresher_core.sv =====
// Graphic LCD serial frame refresher: top level joining front, queue and back.
// Depends on glcd_pkg, glcd_front, glcd_queue and glcd_back.
//
// Usage: framebuffer bytes of a 128x64 monochrome display arrive on the slave
// stream, one byte per request, row by row. s_tuser restarts the frame at byte
// zero with the byte that carries it. The master stream carries serial bytes for
// the display controller: at each row start the command sync, the row and column
// addresses split into nibbles and the data sync, then every pixel byte as its
// high nibble followed by its low nibble shifted up. m_tlast marks the final
// serial byte of each input byte; m_tuser asks for chip select release after
// the last byte of each display half.
// Throughput: the back end emits one serial byte per cycle while the receiver
// is ready; a byte that starts a row gives eight serial bytes, any other byte
// two. A four-entry queue between front and back lets input be taken while
// output is stalled. An accepted item passes through the queue into the output
// register. Reset clears the position to byte zero and empties the queue and
// output register. A stalled receiver simply holds the output register; input
// keeps being taken until the queue fills.
module glcd_serial_frame_refresher_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] pixel_byte
	input  logic       s_tuser,   // [0] frame_start
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] spi_byte
	output logic       m_tuser,   // [0] release_select
	output logic       m_tlast
);
	import glcd_pkg::*;

	logic       q_full;
	logic       q_push;
	glcd_item_t q_item;
	logic       q_pop;
	logic       head_valid;
	glcd_item_t head_item;

	glcd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.pixel_byte  (s_tdata),
		.frame_start (s_tuser),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_item)
	);

	glcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	glcd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_item      (head_item),
		.pop            (q_pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.spi_byte       (m_tdata),
		.release_select (m_tuser),
		.last_of_run    (m_tlast)
	);

endmodule
